@@ src/assert_macros.svh @@
// Assertion macros used by the checker file qdv_checker.sv.
// No dependencies; take this file in by include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define QDV_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Concurrent check that also runs during reset.
`define QDV_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/qdv_pkg.sv @@
// Shared types and constants of the quadrature decoder with velocity estimate.
// No dependencies; every design and checker module imports this package.
package qdv_pkg;

  localparam int POS_W         = 32;
  localparam int VEL_W         = 40;
  localparam int TMR_W         = 32;
  localparam int CFG_W         = 32;
  localparam int CFG_IDX_W     = 2;
  localparam int MODE_W        = 2;
  localparam int MISS_W        = 2;
  localparam int FRAC_BITS_DEF = 8;
  localparam int DIV_STEPS     = VEL_W - 1;
  localparam int CNT_W         = $clog2(DIV_STEPS);

  localparam logic [CFG_W-1:0] TPS_RESET = 32'd60000000;

  localparam logic [MODE_W-1:0] MODE_OFF = 2'd0;
  localparam logic [MODE_W-1:0] MODE_2X  = 2'd1;

  localparam logic [MISS_W-1:0] MISS_NONE = 2'd0;
  localparam logic [MISS_W-1:0] MISS_A    = 2'd1;
  localparam logic [MISS_W-1:0] MISS_B    = 2'd2;

  localparam logic CMD_EDGE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
  localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 2'd0,
    CFG_PERIOD = 2'd1,
    CFG_TPS    = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_CHK,
    ST_DIV,
    ST_FIN,
    ST_WB
  } state_t;

  typedef struct packed {
    logic take_edge;
    logic take_tick;
    logic mul;
    logic chk;
    logic div;
    logic fin;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_on;
    logic div_go;
    logic div_last;
  } dp_stat_t;

endpackage

@@ src/qdv_ctrl.sv @@
// Controller of the quadrature decoder: sequences edge and tick requests.
// Depends on qdv_pkg; drives the datapath through dp_cmd_t.
module qdv_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output qdv_pkg::dp_cmd_t  cmd,
  input  qdv_pkg::dp_stat_t stat
);
  import qdv_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   take;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign take      = in_valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (in_cmd == CMD_TICK && stat.mode_on) begin
            state_nxt = ST_MUL;
          end else begin
            state_nxt = ST_WB;
          end
        end
      end
      ST_MUL: state_nxt = ST_CHK;
      ST_CHK: begin
        state_nxt = stat.div_go ? ST_DIV : ST_WB;
      end
      ST_DIV: begin
        if (stat.div_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: state_nxt = ST_WB;
      ST_WB: begin
        if (slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state_r == ST_IDLE);
    cmd.take_edge = take && (in_cmd == CMD_EDGE);
    cmd.take_tick = take && (in_cmd == CMD_TICK);
    cmd.mul       = (state_r == ST_MUL);
    cmd.chk       = (state_r == ST_CHK);
    cmd.div       = (state_r == ST_DIV);
    cmd.fin       = (state_r == ST_FIN);
    cmd.ld_out    = (state_r == ST_WB) && slot_free;
    // hold the result until taken, refill on load
    if (cmd.ld_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/qdv_dp.sv @@
// Datapath: config registers, quadrature counter, velocity multiply and
// restoring divider, result register. Depends on qdv_pkg; run by qdv_ctrl.
module qdv_dp #(
  parameter int FRAC_BITS = qdv_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [qdv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qdv_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                in_edge_a,
  input  logic                                in_edge_b,
  input  logic                                in_level_a,
  input  logic                                in_level_b,
  input  logic [qdv_pkg::TMR_W-1:0]           in_timer_now,
  input  qdv_pkg::dp_cmd_t                    cmd,
  output qdv_pkg::dp_stat_t                   stat,
  output logic signed [qdv_pkg::POS_W-1:0]    out_position,
  output logic signed [qdv_pkg::VEL_W-1:0]    out_velocity_q8,
  output logic                                out_stopped,
  output logic                                out_both_edges,
  output logic [qdv_pkg::MISS_W-1:0]          out_miss_status
);
  import qdv_pkg::*;

  localparam int PROD_W = 2 * CFG_W;
  localparam int N_W    = PROD_W + FRAC_BITS;
  localparam int HI_W   = N_W - DIV_STEPS;
  localparam int CMP_W  = (HI_W > TMR_W) ? HI_W : TMR_W;
  localparam logic signed [VEL_W-1:0] STOP_LIM   = VEL_W'(((1 << FRAC_BITS) - 1) / 5);
  localparam logic signed [VEL_W-1:0] STOP_LIM_N = -STOP_LIM;

  // configuration
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic [CFG_W-1:0]  period_r, period_nxt;
  logic [CFG_W-1:0]  tps_r, tps_nxt;

  // decoder and velocity state
  logic [POS_W-1:0]        count_now_r, count_now_nxt;
  logic [POS_W-1:0]        count_at_tick_r, count_at_tick_nxt;
  logic                    last_a_r, last_a_nxt;
  logic                    last_b_r, last_b_nxt;
  logic [TMR_W-1:0]        timer_at_tick_r, timer_at_tick_nxt;
  logic signed [VEL_W-1:0] speed_r, speed_nxt;
  logic                    both_r, both_nxt;
  logic [MISS_W-1:0]       miss_r, miss_nxt;

  // divider working set
  logic [TMR_W-1:0]     elapsed_r, elapsed_nxt;
  logic                 neg_r, neg_nxt;
  logic [POS_W-1:0]     magd_r, magd_nxt;
  logic [PROD_W-1:0]    num_r, num_nxt;
  logic [TMR_W-1:0]     rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] lo_r, lo_nxt;
  logic [DIV_STEPS-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;

  // result register
  logic [POS_W-1:0]        out_position_r, out_position_nxt;
  logic signed [VEL_W-1:0] out_velocity_r, out_velocity_nxt;
  logic                    out_stopped_r, out_stopped_nxt;
  logic                    out_both_r, out_both_nxt;
  logic [MISS_W-1:0]       out_miss_r, out_miss_nxt;

  logic              mode_on;
  logic              eb_m;
  logic [POS_W-1:0]  delta;
  logic [POS_W-1:0]  magd;
  logic [N_W-1:0]    numx;
  logic [HI_W-1:0]   hi;
  logic              num_zero;
  logic              ovf;
  logic [TMR_W:0]    trial;
  logic              ge;
  logic [TMR_W-1:0]  rem_step;
  logic              stopped;

  assign mode_on = (mode_r != MODE_OFF);
  assign eb_m    = (mode_r == MODE_2X) ? 1'b0 : in_edge_b;
  assign delta   = count_now_r - count_at_tick_r;
  assign magd    = delta[POS_W-1] ? (POS_W'(0) - delta) : delta;

  // quotient of (num << FRAC_BITS) / elapsed overflows 39 bits
  // exactly when the bits above the quotient field reach elapsed
  assign numx     = N_W'(num_r) << FRAC_BITS;
  assign hi       = numx[N_W-1:DIV_STEPS];
  assign num_zero = (num_r == '0);
  assign ovf      = CMP_W'(hi) >= CMP_W'(elapsed_r);

  assign trial    = {rem_r, lo_r[DIV_STEPS-1]};
  assign ge       = trial >= {1'b0, elapsed_r};
  assign rem_step = ge ? TMR_W'(trial - {1'b0, elapsed_r}) : trial[TMR_W-1:0];

  assign stopped = (speed_r <= STOP_LIM) && (speed_r >= STOP_LIM_N);

  assign stat.mode_on  = mode_on;
  assign stat.div_go   = !num_zero && !ovf;
  assign stat.div_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  always_comb begin
    mode_nxt          = mode_r;
    period_nxt        = period_r;
    tps_nxt           = tps_r;
    count_now_nxt     = count_now_r;
    count_at_tick_nxt = count_at_tick_r;
    last_a_nxt        = last_a_r;
    last_b_nxt        = last_b_r;
    timer_at_tick_nxt = timer_at_tick_r;
    speed_nxt         = speed_r;
    both_nxt          = both_r;
    miss_nxt          = miss_r;
    elapsed_nxt       = elapsed_r;
    neg_nxt           = neg_r;
    magd_nxt          = magd_r;
    num_nxt           = num_r;
    rem_nxt           = rem_r;
    lo_nxt            = lo_r;
    quo_nxt           = quo_r;
    cnt_nxt           = cnt_r;
    out_position_nxt  = out_position_r;
    out_velocity_nxt  = out_velocity_r;
    out_stopped_nxt   = out_stopped_r;
    out_both_nxt      = out_both_r;
    out_miss_nxt      = out_miss_r;

    if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_MODE:   mode_nxt   = cfg_wdata[MODE_W-1:0];
        CFG_PERIOD: period_nxt = cfg_wdata;
        CFG_TPS:    tps_nxt    = cfg_wdata;
        default:    ;
      endcase
    end

    if (cmd.take_edge) begin
      both_nxt = 1'b0;
      miss_nxt = MISS_NONE;
      if (mode_on) begin
        both_nxt = in_edge_a & eb_m;
        // A wins when both channels fire together
        if (in_edge_a) begin
          if (in_level_a == last_a_r) begin
            miss_nxt = MISS_A;
          end else begin
            count_now_nxt = (in_level_a != in_level_b) ? count_now_r + 1'b1
                                                        : count_now_r - 1'b1;
            last_a_nxt    = in_level_a;
          end
        end else if (eb_m) begin
          if (in_level_b == last_b_r) begin
            miss_nxt = MISS_B;
          end else begin
            count_now_nxt = (in_level_a == in_level_b) ? count_now_r + 1'b1
                                                        : count_now_r - 1'b1;
            last_b_nxt    = in_level_b;
          end
        end
      end
    end

    if (cmd.take_tick) begin
      both_nxt          = 1'b0;
      miss_nxt          = MISS_NONE;
      elapsed_nxt       = period_r + (in_timer_now - timer_at_tick_r);
      timer_at_tick_nxt = in_timer_now;
      if (mode_on) begin
        count_at_tick_nxt = count_now_r;
        neg_nxt           = delta[POS_W-1];
        magd_nxt          = magd;
      end
    end

    if (cmd.mul) begin
      num_nxt = PROD_W'(magd_r) * PROD_W'(tps_r);
    end

    if (cmd.chk) begin
      rem_nxt = TMR_W'(hi);
      lo_nxt  = numx[DIV_STEPS-1:0];
      quo_nxt = '0;
      cnt_nxt = '0;
      if (num_zero) begin
        speed_nxt = '0;
      end else if (ovf) begin
        speed_nxt = neg_r ? VEL_MIN : VEL_MAX;
      end
    end

    if (cmd.div) begin
      rem_nxt = rem_step;
      lo_nxt  = lo_r << 1;
      quo_nxt = {quo_r[DIV_STEPS-2:0], ge};
      cnt_nxt = cnt_r + 1'b1;
    end

    if (cmd.fin) begin
      speed_nxt = neg_r ? (VEL_W'(0) - {1'b0, quo_r}) : {1'b0, quo_r};
    end

    if (cmd.ld_out) begin
      out_position_nxt = count_now_r;
      out_velocity_nxt = speed_r;
      out_stopped_nxt  = stopped;
      out_both_nxt     = both_r;
      out_miss_nxt     = miss_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_OFF;
      period_r        <= '0;
      tps_r           <= TPS_RESET;
      count_now_r     <= '0;
      count_at_tick_r <= '0;
      last_a_r        <= 1'b0;
      last_b_r        <= 1'b0;
      timer_at_tick_r <= '0;
      speed_r         <= '0;
      both_r          <= 1'b0;
      miss_r          <= MISS_NONE;
    end else begin
      mode_r          <= mode_nxt;
      period_r        <= period_nxt;
      tps_r           <= tps_nxt;
      count_now_r     <= count_now_nxt;
      count_at_tick_r <= count_at_tick_nxt;
      last_a_r        <= last_a_nxt;
      last_b_r        <= last_b_nxt;
      timer_at_tick_r <= timer_at_tick_nxt;
      speed_r         <= speed_nxt;
      both_r          <= both_nxt;
      miss_r          <= miss_nxt;
    end
  end

  always_ff @(posedge clk) begin
    elapsed_r      <= elapsed_nxt;
    neg_r          <= neg_nxt;
    magd_r         <= magd_nxt;
    num_r          <= num_nxt;
    rem_r          <= rem_nxt;
    lo_r           <= lo_nxt;
    quo_r          <= quo_nxt;
    cnt_r          <= cnt_nxt;
    out_position_r <= out_position_nxt;
    out_velocity_r <= out_velocity_nxt;
    out_stopped_r  <= out_stopped_nxt;
    out_both_r     <= out_both_nxt;
    out_miss_r     <= out_miss_nxt;
  end

  assign out_position    = out_position_r;
  assign out_velocity_q8 = out_velocity_r;
  assign out_stopped     = out_stopped_r;
  assign out_both_edges  = out_both_r;
  assign out_miss_status = out_miss_r;

endmodule

@@ src/quadrature_decoder_velocity_core.sv @@
// Channel  | Handshake          | Carries
// ---------+--------------------+------------------------------------------------
// cfg      | cfg_we             | cfg_index, cfg_wdata (mode, period, ticks/sec)
// in       | in_valid/in_ready  | cmd, edge flags, pin levels, timer count
// out      | out_valid/out_ready| position, velocity_q8, stopped, both, miss
//
// Edge request: accept, result load. Velocity tick: accept, multiply, check,
// restoring divide retiring one quotient bit per cycle, finish, result load;
// no divide when the result is zero or saturates, only accept and load when off.
// One request is in flight at a time; a request is accepted while the previous
// result waits in the output register. Reset is synchronous, active low, and
// needs no clearing pass. A stalled output holds the next result in the datapath.
// Top level of the quadrature decoder with velocity estimate.
// Depends on qdv_pkg, qdv_ctrl and qdv_dp.
module quadrature_decoder_velocity_core #(
  parameter int FRAC_BITS = qdv_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [qdv_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [qdv_pkg::CFG_W-1:0]        cfg_wdata,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_cmd,
  input  logic                             in_edge_a,
  input  logic                             in_edge_b,
  input  logic                             in_level_a,
  input  logic                             in_level_b,
  input  logic [qdv_pkg::TMR_W-1:0]        in_timer_now,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [qdv_pkg::POS_W-1:0] out_position,
  output logic signed [qdv_pkg::VEL_W-1:0] out_velocity_q8,
  output logic                             out_stopped,
  output logic                             out_both_edges,
  output logic [qdv_pkg::MISS_W-1:0]       out_miss_status
);
  import qdv_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  qdv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  qdv_dp #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_edge_a       (in_edge_a),
    .in_edge_b       (in_edge_b),
    .in_level_a      (in_level_a),
    .in_level_b      (in_level_b),
    .in_timer_now    (in_timer_now),
    .cmd             (cmd),
    .stat            (stat),
    .out_position    (out_position),
    .out_velocity_q8 (out_velocity_q8),
    .out_stopped     (out_stopped),
    .out_both_edges  (out_both_edges),
    .out_miss_status (out_miss_status)
  );

endmodule

@@ src/qdv_checker.sv @@
// Port-level checks of the quadrature decoder core, bound to the top level.
// Depends on qdv_pkg and assert_macros.svh.
`include "assert_macros.svh"

module qdv_checker #(
  parameter int FRAC_BITS = qdv_pkg::FRAC_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [qdv_pkg::POS_W-1:0] out_position,
  input logic signed [qdv_pkg::VEL_W-1:0] out_velocity_q8,
  input logic                             out_stopped,
  input logic                             out_both_edges,
  input logic [qdv_pkg::MISS_W-1:0]       out_miss_status
);
  import qdv_pkg::*;

  localparam logic signed [VEL_W-1:0] STOP_LIM   = VEL_W'(((1 << FRAC_BITS) - 1) / 5);
  localparam logic signed [VEL_W-1:0] STOP_LIM_N = -STOP_LIM;

  // stalled result keeps its position and velocity
  `QDV_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_position) && $stable(out_velocity_q8), "stalled result changed")

  // one request in flight: ready drops after every accept
  `QDV_ASSERT(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready, "request accepted while busy")

  // reset empties the output and opens the input
  `QDV_ASSERT_ALWAYS(a_reset_clear, clk, !rst_n |=> !out_valid && in_ready, "reset did not clear channels")

  // with both edges only channel A is processed, so no B miss
  `QDV_ASSERT(a_both_no_b_miss, clk, rst_n, out_valid && out_both_edges |-> out_miss_status != MISS_B, "B miss reported on a simultaneous edge")

  // stopped only for a velocity within plus or minus the threshold
  `QDV_ASSERT(a_stopped_range, clk, rst_n, out_valid && out_stopped |-> out_velocity_q8 <= STOP_LIM && out_velocity_q8 >= STOP_LIM_N, "stopped flag with large velocity")

endmodule

bind quadrature_decoder_velocity_core qdv_checker #(.FRAC_BITS(FRAC_BITS)) u_qdv_checker (.*);
